// ----- rtl/core/lmss_pkg.sv -----
// Shared types and constants for the LED matrix row-scan serializer.
// Holds the request codes, the sequencer state type and the driver slice map.
// No dependencies.
`timescale 1ns / 1ps

package lmss_pkg;

   // Request codes carried on req_type
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_SCAN  = 2'd2;

   // Geometry that does not vary
   localparam int COLS        = 32;
   localparam int GRAY_WORDS  = 24;
   localparam int TOTAL_WORDS = 36;
   localparam int SLICES      = 12;

   // Color channel codes
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // Scan sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FILL,
      ST_PUSH
   } scan_state_type;

   // Driver slices in shift order (group, then slice): 8-column block and channel
   localparam logic [1:0] SLICE_BLK [SLICES] = '{
      2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3
   };
   localparam logic [1:0] SLICE_CH [SLICES] = '{
      CH_GREEN, CH_RED, CH_RED, CH_BLUE, CH_BLUE, CH_GREEN,
      CH_GREEN, CH_RED, CH_RED, CH_BLUE, CH_BLUE, CH_GREEN
   };

endpackage

// ----- rtl/core/lmss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lmss_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/led_matrix_scan_serializer_unit.sv -----
// LED matrix row-scan serializer: frame store with pixel write, clear and row scan.
// Depends on lmss_pkg and lmss_ram.
// Scan flow: a taken scan request enters READ; each word reads its pixels, passes FILL
//   and PUSH, and in PUSH waits until the output register is free.
// Throughput: a write or clear leaves the request side ready; a scan holds it until its
//   last word is pushed, the single frame store read port giving one pixel per cycle.
// Reset: control cleared and all per-entry valid bits dropped, so the store reads zero.
`timescale 1ns / 1ps

module led_matrix_scan_serializer_unit #(
   parameter int ROWS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [4:0]  req_pix_x,
   input  logic [2:0]  req_pix_y,
   input  logic [29:0] req_pixel_color,
   input  logic [2:0]  req_row_index,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [47:0] rsp_shift_word,
   output logic        rsp_load_mode,
   output logic        rsp_latch_after,
   output logic [2:0]  rsp_row_select,
   output logic        rsp_last
);

   localparam int DEPTH  = ROWS * lmss_pkg::COLS;
   localparam int ADDR_W = $clog2(DEPTH);

   // ---------------------------------------------------------------------
   // Registers
   lmss_pkg::scan_state_type state_ff, state_in;
   logic [5:0]        word_ff, word_in;
   logic [2:0]        kcnt_ff, kcnt_in;
   logic [2:0]        row_ff;
   logic              rd_pend_ff;
   logic              rd_valid_ff;
   logic [47:0]       acc_ff;
   logic [DEPTH-1:0]  valid_ff;

   logic              rsp_valid_ff;
   logic [47:0]       rsp_word_ff;
   logic              rsp_mode_ff;
   logic              rsp_latch_ff;
   logic [2:0]        rsp_row_ff;
   logic              rsp_last_ff;

   // ---------------------------------------------------------------------
   // Request decode
   logic req_fire;
   logic row_ok_wr;
   logic row_ok_scan;
   logic do_write;
   logic do_clear;
   logic do_scan;

   assign req_fire    = req_valid && req_ready;
   assign row_ok_wr   = ({1'b0, req_pix_y} < 4'(ROWS));
   assign row_ok_scan = ({1'b0, req_row_index} < 4'(ROWS));
   assign do_write    = req_fire && (req_type == lmss_pkg::REQ_WRITE) && row_ok_wr;
   assign do_clear    = req_fire && (req_type == lmss_pkg::REQ_CLEAR);
   assign do_scan     = req_fire && (req_type == lmss_pkg::REQ_SCAN) && row_ok_scan;

   // ---------------------------------------------------------------------
   // Word position decode
   logic        is_gray;
   logic [3:0]  slice_idx;
   logic [1:0]  slice_blk;
   logic [1:0]  slice_ch;
   logic [2:0]  pix_idx;
   logic [2:0]  last_k;
   logic        word_latch;
   logic        word_last;
   logic [5:0]  dc_word;

   assign is_gray    = (word_ff < 6'(lmss_pkg::GRAY_WORDS));
   assign dc_word    = word_ff - 6'(lmss_pkg::GRAY_WORDS);
   assign slice_idx  = is_gray ? word_ff[4:1] : dc_word[3:0];
   assign slice_blk  = lmss_pkg::SLICE_BLK[slice_idx];
   assign slice_ch   = lmss_pkg::SLICE_CH[slice_idx];
   // column low bits run from 7 down; a gray word covers one half of the slice
   assign pix_idx    = is_gray ? {word_ff[0], kcnt_ff[1:0]} : kcnt_ff;
   assign last_k     = is_gray ? 3'd3 : 3'd7;
   assign word_latch = is_gray ? (word_ff[1] & word_ff[0]) : dc_word[0];
   assign word_last  = (word_ff == 6'(lmss_pkg::TOTAL_WORDS - 1));

   // ---------------------------------------------------------------------
   // Sequencer control outputs
   logic rd_en;
   logic out_free;
   logic push_go;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      push_go   = 1'b0;
      unique case (state_ff)
         lmss_pkg::ST_IDLE: req_ready = 1'b1;
         lmss_pkg::ST_READ: rd_en     = 1'b1;
         lmss_pkg::ST_FILL: ;
         lmss_pkg::ST_PUSH: push_go   = out_free;
         default: ;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmss_pkg::ST_IDLE: if (do_scan) state_in = lmss_pkg::ST_READ;
         lmss_pkg::ST_READ: if (kcnt_ff == last_k) state_in = lmss_pkg::ST_FILL;
         lmss_pkg::ST_FILL: state_in = lmss_pkg::ST_PUSH;
         lmss_pkg::ST_PUSH: begin
            if (push_go) begin
               state_in = word_last ? lmss_pkg::ST_IDLE : lmss_pkg::ST_READ;
            end
         end
         default: state_in = lmss_pkg::ST_IDLE;
      endcase
   end

   // Counters
   always_comb begin
      word_in = word_ff;
      kcnt_in = kcnt_ff;
      if (do_scan) begin
         word_in = '0;
         kcnt_in = '0;
      end else if (rd_en) begin
         kcnt_in = kcnt_ff + 3'd1;
      end else if (push_go) begin
         word_in = word_ff + 6'd1;
         kcnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lmss_pkg::ST_IDLE;
         word_ff    <= '0;
         kcnt_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         word_ff    <= word_in;
         kcnt_ff    <= kcnt_in;
         rd_pend_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (do_scan) begin
         row_ff <= req_row_index;
      end
   end

   // ---------------------------------------------------------------------
   // Frame store; writes only in idle, reads only while scanning, so no overlap
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [29:0]       rd_data;

   assign wr_addr = ADDR_W'({req_pix_y, req_pix_x});
   assign rd_addr = ADDR_W'({row_ff, slice_blk, ~pix_idx});

   lmss_ram #(
      .WIDTH (30),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_color),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Per-entry valid bits: an entry not written since clear reads as zero
   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         valid_ff <= '0;
      end else if (do_write) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Word assembly: shift in one value per returned pixel
   logic [29:0] pix;
   logic [7:0]  chan_val;

   assign pix = rd_valid_ff ? rd_data : '0;

   always_comb begin
      unique case (slice_ch)
         lmss_pkg::CH_RED:   chan_val = pix[23:16];
         lmss_pkg::CH_GREEN: chan_val = pix[15:8];
         lmss_pkg::CH_BLUE:  chan_val = pix[7:0];
         default:            chan_val = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         if (is_gray) begin
            acc_ff <= {acc_ff[35:0], chan_val, 4'b0000};
         end else begin
            acc_ff <= {acc_ff[41:0], pix[29:24]};
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_go) begin
         rsp_word_ff  <= acc_ff;
         rsp_mode_ff  <= !is_gray;
         rsp_latch_ff <= word_latch;
         rsp_row_ff   <= row_ff;
         rsp_last_ff  <= word_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shift_word  = rsp_word_ff;
   assign rsp_load_mode   = rsp_mode_ff;
   assign rsp_latch_after = rsp_latch_ff;
   assign rsp_row_select  = rsp_row_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   // a pending read always comes from a read cycle
   a_rd_from_read: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(state_ff == lmss_pkg::ST_READ))
      else $error("read data pending without a read cycle");

   // the word is complete before it is pushed
   a_push_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lmss_pkg::ST_PUSH) |-> !rd_pend_ff)
      else $error("push while pixel data still in flight");

   // word counter stays inside the scan
   a_word_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lmss_pkg::ST_IDLE) |-> (word_ff < 6'(lmss_pkg::TOTAL_WORDS)))
      else $error("word counter out of range");

   // final word of a scan is dot correction data
   a_last_is_dc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_mode_ff && rsp_latch_ff))
      else $error("last word is not a latched dot correction word");
`endif

endmodule

// ----- tb/sv/lmss_scan_checker.sv -----
// Scoreboard for the LED matrix row-scan serializer: mirrors the frame store,
// predicts the 36 shift words of every accepted row scan and compares results in order.
// Depends on lmss_pkg (request and color channel codes, column count).
`timescale 1ns / 1ps

module lmss_scan_checker #(
   parameter int ROWS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [4:0]  req_pix_x,
   input  logic [2:0]  req_pix_y,
   input  logic [29:0] req_pixel_color,
   input  logic [2:0]  req_row_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [47:0] rsp_shift_word,
   input  logic        rsp_load_mode,
   input  logic        rsp_latch_after,
   input  logic [2:0]  rsp_row_select,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_words
);

   localparam int SLICE_COUNT = 12;

   typedef struct packed {
      logic [47:0] shift_word;
      logic        load_mode;
      logic        latch_after;
      logic [2:0]  row_select;
      logic        last;
   } scan_word_type;

   logic [29:0]   pixel_mirror [ROWS][lmss_pkg::COLS];
   scan_word_type expected_words [$];

   // Driver slices in shift order: first column of the 8-column slice and its channel
   function automatic void slice_of(input int idx, output int col_base,
                                    output logic [1:0] color);
      case (idx)
         0:       begin col_base = 0;  color = lmss_pkg::CH_GREEN; end
         1:       begin col_base = 0;  color = lmss_pkg::CH_RED;   end
         2:       begin col_base = 8;  color = lmss_pkg::CH_RED;   end
         3:       begin col_base = 0;  color = lmss_pkg::CH_BLUE;  end
         4:       begin col_base = 8;  color = lmss_pkg::CH_BLUE;  end
         5:       begin col_base = 8;  color = lmss_pkg::CH_GREEN; end
         6:       begin col_base = 16; color = lmss_pkg::CH_GREEN; end
         7:       begin col_base = 16; color = lmss_pkg::CH_RED;   end
         8:       begin col_base = 24; color = lmss_pkg::CH_RED;   end
         9:       begin col_base = 16; color = lmss_pkg::CH_BLUE;  end
         10:      begin col_base = 24; color = lmss_pkg::CH_BLUE;  end
         default: begin col_base = 24; color = lmss_pkg::CH_GREEN; end
      endcase
   endfunction

   function automatic logic [7:0] channel_of(input logic [29:0] pix, input logic [1:0] color);
      case (color)
         lmss_pkg::CH_RED:   return pix[23:16];
         lmss_pkg::CH_GREEN: return pix[15:8];
         default:            return pix[7:0];
      endcase
   endfunction

   // Queue the 24 grayscale words and 12 dot-correction words of one row
   function automatic void predict_row_scan(input logic [2:0] row);
      scan_word_type w;
      int col_base;
      int col;
      logic [1:0] color;
      // grayscale: two words per slice, four 12-bit values each, high column first
      for (int i = 0; i < SLICE_COUNT; i++) begin
         slice_of(i, col_base, color);
         for (int h = 0; h < 2; h++) begin
            w = '0;
            for (int k = 0; k < 4; k++) begin
               col = col_base + 7 - 4 * h - k;
               w.shift_word = {w.shift_word[35:0], channel_of(pixel_mirror[row][col], color),
                               4'b0000};
            end
            w.latch_after = (i % 2 == 1) && (h == 1);
            w.row_select  = row;
            expected_words.push_back(w);
         end
      end
      // dot correction: one word per slice, eight 6-bit values
      for (int i = 0; i < SLICE_COUNT; i++) begin
         slice_of(i, col_base, color);
         w = '0;
         for (int k = 0; k < 8; k++) begin
            col = col_base + 7 - k;
            w.shift_word = {w.shift_word[41:0], pixel_mirror[row][col][29:24]};
         end
         w.load_mode   = 1'b1;
         w.latch_after = (i % 2 == 1);
         w.row_select  = row;
         w.last        = (i == SLICE_COUNT - 1);
         expected_words.push_back(w);
      end
   endfunction

   function automatic void check_field(input string name, input logic [47:0] want,
                                       input logic [47:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Track accepted requests and compare every accepted result word
   always @(posedge clock) begin : watch_channels
      scan_word_type got;
      scan_word_type want;
      if (reset) begin
         fail_count = 0;
         expected_words.delete();
         for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < lmss_pkg::COLS; c++)
               pixel_mirror[r][c] = '0;
      end else begin
         if (req_valid && req_ready) begin
            case (req_type)
               lmss_pkg::REQ_WRITE: begin
                  if (int'(req_pix_y) < ROWS)
                     pixel_mirror[req_pix_y][req_pix_x] = req_pixel_color;
               end
               lmss_pkg::REQ_CLEAR: begin
                  for (int r = 0; r < ROWS; r++)
                     for (int c = 0; c < lmss_pkg::COLS; c++)
                        pixel_mirror[r][c] = '0;
               end
               lmss_pkg::REQ_SCAN: begin
                  if (int'(req_row_index) < ROWS)
                     predict_row_scan(req_row_index);
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_shift_word, rsp_load_mode, rsp_latch_after, rsp_row_select, rsp_last};
            if (expected_words.size() == 0) begin
               $error("unexpected shift word %0h with no scan pending", rsp_shift_word);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("shift_word", want.shift_word, got.shift_word);
               check_field("load_mode", 48'(want.load_mode), 48'(got.load_mode));
               check_field("latch_after", 48'(want.latch_after), 48'(got.latch_after));
               check_field("row_select", 48'(want.row_select), 48'(got.row_select));
               check_field("last", 48'(want.last), 48'(got.last));
            end
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

// ----- tb/sv/led_matrix_scan_serializer_unit_tb.sv -----
// Testbench top for the LED matrix row-scan serializer: drives pixel writes, clears
// and row scans with bursty requests and a stalling result sink, and gives the verdict.
// Depends on lmss_pkg, led_matrix_scan_serializer_unit and lmss_scan_checker.
`timescale 1ns / 1ps

module led_matrix_scan_serializer_unit_tb;

   localparam int ROWS             = 8;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS  = 250;
   localparam int IDLE_LIMIT       = 4000;
   localparam int LONG_HOLD_CYCLES = 700;
   localparam int LONG_HOLD_AFTER  = 40;
   localparam int TAIL_CYCLES      = 40;

   // result sink stall patterns
   localparam int SINK_OPEN   = 0;
   localparam int SINK_RANDOM = 1;
   localparam int SINK_TOGGLE = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = lmss_pkg::REQ_WRITE;
   logic [4:0]  req_pix_x = '0;
   logic [2:0]  req_pix_y = '0;
   logic [29:0] req_pixel_color = '0;
   logic [2:0]  req_row_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [47:0] rsp_shift_word;
   logic        rsp_load_mode;
   logic        rsp_latch_after;
   logic [2:0]  rsp_row_select;
   logic        rsp_last;
   int          fail_count;
   int          pending_words;
   int          idle_cycles = 0;
   int          words_received = 0;
   int          burst_left = 0;

   led_matrix_scan_serializer_unit #(.ROWS(ROWS)) DUT (.*);

   lmss_scan_checker #(.ROWS(ROWS)) scoreboard (.*);

   always #5 clock = ~clock;

   // Cycles without any handshake, and result words taken so far
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && rsp_ready)
         words_received <= words_received + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $display("** led_matrix_scan_serializer_unit: FAILED **");
      $finish;
   end

   // Zero, all ones or mostly random, so every color bit toggles
   function automatic logic [29:0] random_color();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return 30'($urandom_range(0, 32'h3FFF_FFFF));
      endcase
   endfunction

   // Offer one request at the falling edge and hold it until taken; gaps between bursts
   task automatic send_request(input logic [1:0] kind, input logic [4:0] x,
                               input logic [2:0] y, input logic [29:0] color,
                               input logic [2:0] row);
      int gap;
      @(negedge clock);
      req_type        = kind;
      req_pix_x       = x;
      req_pix_y       = y;
      req_pixel_color = color;
      req_row_index   = row;
      req_valid       = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // Result sink: stretches of stall patterns, one long hold-off once scans are flowing
   initial begin : result_sink
      int stretch;
      int pattern;
      bit long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         if (!long_hold_done && words_received >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            repeat (LONG_HOLD_CYCLES) begin
               @(negedge clock);
               rsp_ready = 1'b0;
            end
         end
         pattern = $urandom_range(SINK_OPEN, SINK_TOGGLE);
         stretch = $urandom_range(10, 80);
         repeat (stretch) begin
            @(negedge clock);
            case (pattern)
               SINK_OPEN:   rsp_ready = 1'b1;
               SINK_RANDOM: rsp_ready = ($urandom_range(0, 2) == 0);
               default:     rsp_ready = ~rsp_ready;
            endcase
         end
      end
   end

   initial begin : stimulus
      int issued;
      int fill_len;
      logic [2:0] row;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty store, corner and slice-edge pixels, unused code, clear
      send_request(lmss_pkg::REQ_SCAN, 5'd0, 3'd0, '0, 3'd0);
      send_request(lmss_pkg::REQ_WRITE, 5'd0, 3'd0, '1, 3'd0);
      send_request(lmss_pkg::REQ_WRITE, 5'd31, 3'd0, 30'h1555_5555, 3'd0);
      send_request(lmss_pkg::REQ_WRITE, 5'd7, 3'd0, 30'h2AAA_AAAA, 3'd0);
      send_request(lmss_pkg::REQ_WRITE, 5'd8, 3'd0, 30'h3F00_FF00, 3'd0);
      send_request(lmss_pkg::REQ_WRITE, 5'd16, 3'd0, 30'h0000_00FF, 3'd0);
      send_request(lmss_pkg::REQ_WRITE, 5'd24, 3'd0, 30'h00FF_0000, 3'd0);
      send_request(lmss_pkg::REQ_WRITE, 5'd23, 3'd0, 30'h0100_0001, 3'd0);
      send_request(lmss_pkg::REQ_SCAN, 5'd31, 3'd7, '1, 3'd0);
      send_request(lmss_pkg::REQ_WRITE, 5'd0, 3'd7, '1, 3'd7);
      send_request(lmss_pkg::REQ_WRITE, 5'd31, 3'd7, '1, 3'd7);
      send_request(lmss_pkg::REQ_WRITE, 5'd15, 3'd7, 30'h3E80_4020, 3'd7);
      send_request(lmss_pkg::REQ_SCAN, 5'd0, 3'd0, '0, 3'd7);
      // unused request code must leave the store alone and emit nothing
      send_request(REQ_UNUSED, 5'd31, 3'd7, '1, 3'd7);
      send_request(REQ_UNUSED, 5'd0, 3'd0, '0, 3'd0);
      send_request(lmss_pkg::REQ_SCAN, 5'd0, 3'd0, '0, 3'd0);
      send_request(lmss_pkg::REQ_CLEAR, 5'd31, 3'd7, '1, 3'd7);
      send_request(lmss_pkg::REQ_SCAN, 5'd0, 3'd0, '0, 3'd7);
      // overwrite of the same pixel: only the second value survives
      send_request(lmss_pkg::REQ_WRITE, 5'd5, 3'd3, 30'h2345_6789, 3'd0);
      send_request(lmss_pkg::REQ_WRITE, 5'd5, 3'd3, 30'h1ABC_DEF0, 3'd0);
      send_request(lmss_pkg::REQ_SCAN, 5'd0, 3'd0, '0, 3'd3);

      // random: mostly partial row fills followed by a scan of that row, some noise
      issued = 0;
      while (issued < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 4) != 0) begin
            row      = 3'($urandom_range(0, ROWS - 1));
            fill_len = $urandom_range(2, 10);
            repeat (fill_len)
               send_request(lmss_pkg::REQ_WRITE, 5'($urandom_range(0, 31)), row,
                            random_color(), 3'($urandom_range(0, 7)));
            send_request(lmss_pkg::REQ_SCAN, 5'($urandom_range(0, 31)),
                         3'($urandom_range(0, 7)), random_color(), row);
            issued += fill_len + 1;
         end else begin
            case ($urandom_range(0, 5))
               0: begin
                  send_request(lmss_pkg::REQ_CLEAR, 5'($urandom_range(0, 31)),
                               3'($urandom_range(0, 7)), random_color(),
                               3'($urandom_range(0, 7)));
                  issued++;
               end
               1: send_request(REQ_UNUSED, 5'($urandom_range(0, 31)),
                               3'($urandom_range(0, 7)), random_color(),
                               3'($urandom_range(0, 7)));
               2: begin
                  send_request(lmss_pkg::REQ_SCAN, 5'($urandom_range(0, 31)),
                               3'($urandom_range(0, 7)), random_color(),
                               3'($urandom_range(0, ROWS - 1)));
                  issued++;
               end
               default: begin
                  send_request(lmss_pkg::REQ_WRITE, 5'($urandom_range(0, 31)),
                               3'($urandom_range(0, 7)), random_color(),
                               3'($urandom_range(0, 7)));
                  issued++;
               end
            endcase
         end
      end

      // drain: wait for every predicted word, then a short quiet tail
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_words != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** led_matrix_scan_serializer_unit: PASSED **");
      else
         $display("** led_matrix_scan_serializer_unit: FAILED **");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/lmss_pkg.sv
rtl/core/lmss_ram.sv
rtl/core/led_matrix_scan_serializer_unit.sv
tb/sv/lmss_scan_checker.sv
tb/sv/led_matrix_scan_serializer_unit_tb.sv
